// ===== design/ssa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ssa_pkg;

    localparam int MAX_STATIONS   = 512;
    localparam int MAX_NAME_BYTES = 128;
    localparam int IDX_W  = $clog2(MAX_STATIONS);
    localparam int OFF_W  = $clog2(MAX_NAME_BYTES);
    localparam int NADDR_W = IDX_W + OFF_W;
    localparam int LEN_W  = 8;
    localparam int TOT_W  = IDX_W + 1;

    localparam logic signed [18:0] TEMP_LIMIT = 19'sd9999;
    localparam logic signed [56:0] SUM_MAX = 57'sh00_7FFF_FFFF_FFFF_FF;
    localparam logic signed [56:0] SUM_MIN = -SUM_MAX - 57'sd1;
    localparam logic [39:0] COUNT_MAX = 40'hFF_FFFF_FFFF;

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    localparam logic [1:0] MODE_BYTE  = 2'd0;
    localparam logic [1:0] MODE_STATS = 2'd1;
    localparam logic [1:0] MODE_NAME  = 2'd2;
    localparam logic [1:0] MODE_FLUSH = 2'd3;

    localparam logic [1:0] PH_NAME      = 2'd0;
    localparam logic [1:0] PH_NAME_LONG = 2'd1;
    localparam logic [1:0] PH_TEMP      = 2'd2;
    localparam logic [1:0] PH_TEMP_LONG = 2'd3;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [14:0]      tmin;
        logic [14:0]      tmax;
        logic [55:0]      sum;
        logic [39:0]      cnt;
    } stat_t;

endpackage
`default_nettype wire

// ===== design/station_stats_aggregator_top.sv =====
// Station statistics aggregator. Bytes of "name;temperature" lines enter as
// words with tuser = 0; tuser = 3 closes a pending line, tuser = 1 and 2 read
// an entry's statistics or one stored name byte. A data byte is taken in the
// idle state; a read passes S_RD, then S_RDW, which waits on a full output.
// A line end runs a linear search through the stats and name memories: each
// table entry's length is checked, names of equal length are compared byte by
// byte, then a match is updated, or a new station is inserted with its name
// copied. No clearing pass: entries are only read below the fill count.
`timescale 1ns / 1ps
`default_nettype none
module station_stats_aggregator_top
    import ssa_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [23:0]  s_tdata,   // data_byte, entry_index, name_offset
    input  wire logic [1:0]   s_tuser,   // mode
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [159:0]      m_tdata    // entry_valid, min_temp, max_temp, temp_sum,
                                         // sample_count, name_length, name_byte,
                                         // entries_used, table_full_drop,
                                         // long_name_drop
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_LEN    = 4'd1;
    localparam logic [3:0] S_LENCHK = 4'd2;
    localparam logic [3:0] S_CMP    = 4'd3;
    localparam logic [3:0] S_UPD    = 4'd4;
    localparam logic [3:0] S_COPY   = 4'd5;
    localparam logic [3:0] S_COPYWR = 4'd6;
    localparam logic [3:0] S_RD     = 4'd7;
    localparam logic [3:0] S_RDW    = 4'd8;

    logic [3:0]              state_reg, state_next;
    logic [1:0]              ph_reg, ph_next;
    logic [LEN_W-1:0]        llen_reg, llen_next;
    logic signed [14:0]      acc_reg, acc_next;
    logic                    neg_reg, neg_next;
    logic                    first_reg, first_next;
    logic [TOT_W-1:0]        total_reg, total_next;
    logic                    full_reg, full_next;
    logic                    long_reg, long_next;
    logic signed [14:0]      t_reg, t_next;
    logic [TOT_W-1:0]        e_reg, e_next;
    logic [LEN_W-1:0]        k_reg, k_next;
    logic [IDX_W-1:0]        ridx_reg, ridx_next;
    logic [OFF_W-1:0]        roff_reg, roff_next;
    logic                    rname_reg, rname_next;
    logic                    ov_reg, ov_next;
    logic [154:0]            od_reg, od_next;

    logic [7:0]              lb_mem [MAX_NAME_BYTES];
    logic                    lb_we, lb_re;
    logic [OFF_W-1:0]        lb_waddr, lb_raddr;
    logic [7:0]              lb_wdata, lb_rdata;

    logic [7:0]              nm_mem [MAX_STATIONS*MAX_NAME_BYTES];
    logic                    nm_we, nm_re;
    logic [NADDR_W-1:0]      nm_waddr, nm_raddr;
    logic [7:0]              nm_wdata, nm_rdata;

    stat_t                   st_mem [MAX_STATIONS];
    logic                    st_we, st_re;
    logic [IDX_W-1:0]        st_waddr, st_raddr;
    stat_t                   st_wdata, st_rdata;

    logic                    acc_in;
    logic [1:0]              in_mode;
    logic [7:0]              in_byte;
    logic [IDX_W-1:0]        in_idx;
    logic [OFF_W-1:0]        in_off;
    logic signed [18:0]      v;
    logic signed [56:0]      sum_x;
    logic                    rvalid;
    logic [7:0]              rbyte;
    logic [LEN_W-1:0]        k_inc;

    assign in_mode  = s_tuser;
    assign in_byte  = s_tdata[7:0];
    assign in_idx   = s_tdata[8 +: IDX_W];
    assign in_off   = s_tdata[17 +: OFF_W];
    assign s_tready = (state_reg == S_IDLE);
    assign acc_in   = s_tvalid && s_tready;
    assign m_tvalid = ov_reg;
    assign m_tdata  = {5'd0, od_reg};
    assign k_inc    = k_reg + LEN_W'(1);

    assign v = 19'(acc_reg) * 19'sd10 + 19'($signed({1'b0, in_byte}))
               - 19'($signed({1'b0, CH_ZERO}));
    assign sum_x = 57'($signed(st_rdata.sum)) + 57'(t_reg);
    assign rvalid = (TOT_W'(ridx_reg) < total_reg);
    assign rbyte = (rname_reg && rvalid && (LEN_W'(roff_reg) < st_rdata.len))
                   ? nm_rdata : 8'd0;

    always_ff @(posedge clk)
    begin
        if (lb_we)
        begin
            lb_mem[lb_waddr] <= lb_wdata;
        end
        if (lb_re)
        begin
            lb_rdata <= lb_mem[lb_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (nm_we)
        begin
            nm_mem[nm_waddr] <= nm_wdata;
        end
        if (nm_re)
        begin
            nm_rdata <= nm_mem[nm_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            st_mem[st_waddr] <= st_wdata;
        end
        if (st_re)
        begin
            st_rdata <= st_mem[st_raddr];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ph_next    = ph_reg;
        llen_next  = llen_reg;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        first_next = first_reg;
        total_next = total_reg;
        full_next  = full_reg;
        long_next  = long_reg;
        t_next     = t_reg;
        e_next     = e_reg;
        k_next     = k_reg;
        ridx_next  = ridx_reg;
        roff_next  = roff_reg;
        rname_next = rname_reg;
        ov_next    = ov_reg && !m_tready;
        od_next    = od_reg;
        lb_we = 1'b0; lb_waddr = llen_reg[OFF_W-1:0]; lb_wdata = in_byte;
        lb_re = 1'b0; lb_raddr = '0;
        nm_we = 1'b0; nm_waddr = {e_reg[IDX_W-1:0], k_reg[OFF_W-1:0]};
        nm_wdata = lb_rdata;
        nm_re = 1'b0; nm_raddr = '0;
        st_we = 1'b0; st_waddr = e_reg[IDX_W-1:0]; st_wdata = st_rdata;
        st_re = 1'b0; st_raddr = e_reg[IDX_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (acc_in)
                begin
                    if (in_mode == MODE_STATS || in_mode == MODE_NAME)
                    begin
                        ridx_next  = in_idx;
                        roff_next  = in_off;
                        rname_next = (in_mode == MODE_NAME);
                        state_next = S_RD;
                    end
                    else if (in_mode == MODE_FLUSH || in_byte == CH_NL)
                    begin
                        if (ph_reg == PH_TEMP_LONG)
                        begin
                            long_next  = 1'b1;
                        end
                        else if (ph_reg == PH_TEMP)
                        begin
                            t_next     = neg_reg ? -acc_reg : acc_reg;
                            e_next     = '0;
                            state_next = S_LEN;
                        end
                        if (ph_reg != PH_TEMP)
                        begin
                            ph_next    = PH_NAME;
                            llen_next  = '0;
                            acc_next   = '0;
                            neg_next   = 1'b0;
                            first_next = 1'b1;
                        end
                    end
                    else if (ph_reg == PH_NAME || ph_reg == PH_NAME_LONG)
                    begin
                        if (in_byte == CH_SEMI)
                        begin
                            ph_next = (ph_reg == PH_NAME) ? PH_TEMP : PH_TEMP_LONG;
                        end
                        else if (ph_reg == PH_NAME)
                        begin
                            if (llen_reg < LEN_W'(MAX_NAME_BYTES))
                            begin
                                lb_we     = 1'b1;
                                llen_next = llen_reg + LEN_W'(1);
                            end
                            else
                            begin
                                ph_next = PH_NAME_LONG;
                            end
                        end
                    end
                    else if (first_reg && in_byte == CH_MINUS)
                    begin
                        neg_next   = 1'b1;
                        first_next = 1'b0;
                    end
                    else
                    begin
                        first_next = 1'b0;
                        if (in_byte != CH_DOT)
                        begin
                            if (v > TEMP_LIMIT)
                            begin
                                acc_next = 15'(TEMP_LIMIT);
                            end
                            else if (v < -TEMP_LIMIT)
                            begin
                                acc_next = 15'(-TEMP_LIMIT);
                            end
                            else
                            begin
                                acc_next = 15'(v);
                            end
                        end
                    end
                end
            end
            S_LEN:
            begin
                if (e_reg == total_reg)
                begin
                    if (total_reg < TOT_W'(MAX_STATIONS))
                    begin
                        st_we      = 1'b1;
                        st_wdata   = '{len: llen_reg, tmin: t_reg, tmax: t_reg,
                                       sum: 56'(t_reg), cnt: 40'd1};
                        total_next = total_reg + TOT_W'(1);
                        k_next     = '0;
                        state_next = S_COPY;
                    end
                    else
                    begin
                        full_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    st_re      = 1'b1;
                    state_next = S_LENCHK;
                end
            end
            S_LENCHK:
            begin
                if (st_rdata.len == llen_reg)
                begin
                    if (llen_reg == '0)
                    begin
                        state_next = S_UPD;
                    end
                    else
                    begin
                        lb_re      = 1'b1;
                        nm_re      = 1'b1;
                        nm_raddr   = {e_reg[IDX_W-1:0], {OFF_W{1'b0}}};
                        k_next     = '0;
                        state_next = S_CMP;
                    end
                end
                else
                begin
                    e_next     = e_reg + TOT_W'(1);
                    state_next = S_LEN;
                end
            end
            S_CMP:
            begin
                lb_re    = 1'b1;
                nm_re    = 1'b1;
                lb_raddr = k_inc[OFF_W-1:0];
                nm_raddr = {e_reg[IDX_W-1:0], k_inc[OFF_W-1:0]};
                if (lb_rdata != nm_rdata)
                begin
                    e_next     = e_reg + TOT_W'(1);
                    state_next = S_LEN;
                end
                else if (k_inc == llen_reg)
                begin
                    state_next = S_UPD;
                end
                else
                begin
                    k_next = k_inc;
                end
            end
            S_UPD:
            begin
                st_we = 1'b1;
                if (t_reg < $signed(st_rdata.tmin))
                begin
                    st_wdata.tmin = t_reg;
                end
                if (t_reg > $signed(st_rdata.tmax))
                begin
                    st_wdata.tmax = t_reg;
                end
                if (sum_x > SUM_MAX)
                begin
                    st_wdata.sum = 56'(SUM_MAX);
                end
                else if (sum_x < SUM_MIN)
                begin
                    st_wdata.sum = 56'(SUM_MIN);
                end
                else
                begin
                    st_wdata.sum = 56'(sum_x);
                end
                if (st_rdata.cnt != COUNT_MAX)
                begin
                    st_wdata.cnt = st_rdata.cnt + 40'd1;
                end
                state_next = S_IDLE;
            end
            S_COPY:
            begin
                if (k_reg == llen_reg)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    lb_re      = 1'b1;
                    lb_raddr   = k_reg[OFF_W-1:0];
                    state_next = S_COPYWR;
                end
            end
            S_COPYWR:
            begin
                nm_we      = 1'b1;
                k_next     = k_inc;
                state_next = S_COPY;
            end
            S_RD:
            begin
                st_re      = 1'b1;
                st_raddr   = ridx_reg;
                nm_re      = 1'b1;
                nm_raddr   = {ridx_reg, roff_reg};
                state_next = S_RDW;
            end
            S_RDW:
            begin
                if (!ov_reg || m_tready)
                begin
                    ov_next = 1'b1;
                    od_next = {long_reg, full_reg, total_reg, rbyte,
                               rvalid ? st_rdata.len  : 8'd0,
                               rvalid ? st_rdata.cnt  : 40'd0,
                               rvalid ? st_rdata.sum  : 56'd0,
                               rvalid ? st_rdata.tmax : 15'd0,
                               rvalid ? st_rdata.tmin : 15'd0,
                               rvalid};
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (state_reg != S_IDLE && state_reg != S_RD && state_reg != S_RDW
            && state_next == S_IDLE)
        begin
            ph_next    = PH_NAME;
            llen_next  = '0;
            acc_next   = '0;
            neg_next   = 1'b0;
            first_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ph_reg    <= PH_NAME;
            llen_reg  <= '0;
            acc_reg   <= '0;
            neg_reg   <= 1'b0;
            first_reg <= 1'b1;
            total_reg <= '0;
            full_reg  <= 1'b0;
            long_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ph_reg    <= ph_next;
            llen_reg  <= llen_next;
            acc_reg   <= acc_next;
            neg_reg   <= neg_next;
            first_reg <= first_next;
            total_reg <= total_next;
            full_reg  <= full_next;
            long_reg  <= long_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg     <= t_next;
        e_reg     <= e_next;
        k_reg     <= k_next;
        ridx_reg  <= ridx_next;
        roff_reg  <= roff_next;
        rname_reg <= rname_next;
        od_reg    <= od_next;
    end

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= TOT_W'(MAX_STATIONS))
        else $error("station count beyond table size");

    a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
        (total_reg == $past(total_reg)) || (total_reg == $past(total_reg) + TOT_W'(1)))
        else $error("station count jumped");

    a_byte_no_word: assert property (@(posedge clk) disable iff (!rst_n)
        (acc_in && in_mode == MODE_BYTE && !ov_reg) |=> !ov_reg)
        else $error("data byte produced an output word");

    a_llen_bound: assert property (@(posedge clk) disable iff (!rst_n)
        llen_reg <= LEN_W'(MAX_NAME_BYTES))
        else $error("line name length overflow");

endmodule
`default_nettype wire

// ===== tb/station_stats_checker.sv =====
`timescale 1ns / 1ps
module station_stats_checker
    import ssa_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [23:0]  s_tdata,   // data_byte, entry_index, name_offset
    input  wire logic [1:0]   s_tuser,   // mode
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [159:0] m_tdata,   // entry_valid, min_temp, max_temp, temp_sum,
                                         // sample_count, name_length, name_byte,
                                         // entries_used, table_full_drop,
                                         // long_name_drop
    output int                errors,
    output int                pending
);

    localparam int NF = 10;
    localparam int FLO[NF] = '{0, 1, 16, 31, 87, 127, 135, 143, 153, 154};
    localparam int FW[NF]  = '{1, 15, 15, 56, 40, 8, 8, 10, 1, 1};
    localparam string FNAME[NF] = '{"entry_valid", "min_temp", "max_temp", "temp_sum",
        "sample_count", "name_length", "name_byte", "entries_used",
        "table_full_drop", "long_name_drop"};

    logic [159:0] expected_stats[$];

    logic [1:0]  ph;
    logic [7:0]  lbuf[MAX_NAME_BYTES];
    int          nlen;
    int          tacc;
    bit          tneg;
    bit          tfirst;
    logic [7:0]  names[MAX_STATIONS][MAX_NAME_BYTES];
    int          slen[MAX_STATIONS];
    int          smin[MAX_STATIONS];
    int          smax[MAX_STATIONS];
    longint      ssum[MAX_STATIONS];
    longint      scnt[MAX_STATIONS];
    int          total;
    bit          full_flag;
    bit          long_flag;

    initial
    begin
        errors  = 0;
        pending = 0;
    end

    task automatic report(input string what, input logic [159:0] got, input logic [159:0] want);
        $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic void clear_line();
        ph     = PH_NAME;
        nlen   = 0;
        tacc   = 0;
        tneg   = 0;
        tfirst = 1;
    endfunction

    function automatic void close_line();
        int e;
        int t;
        bit same;
        if (ph == PH_TEMP_LONG)
            long_flag = 1;
        else if (ph == PH_TEMP)
        begin
            t = tneg ? -tacc : tacc;
            for (e = 0; e < total; e++)
            begin
                same = (slen[e] == nlen);
                for (int k = 0; k < nlen && same; k++)
                    if (names[e][k] != lbuf[k])
                        same = 0;
                if (same)
                    break;
            end
            if (e < total)
            begin
                if (t < smin[e]) smin[e] = t;
                if (t > smax[e]) smax[e] = t;
                ssum[e] += t;
                if (ssum[e] > longint'(SUM_MAX)) ssum[e] = longint'(SUM_MAX);
                if (ssum[e] < longint'(SUM_MIN)) ssum[e] = longint'(SUM_MIN);
                if (scnt[e] < longint'(COUNT_MAX)) scnt[e]++;
            end
            else if (total < MAX_STATIONS)
            begin
                for (int k = 0; k < nlen; k++)
                    names[e][k] = lbuf[k];
                slen[e] = nlen;
                smin[e] = t;
                smax[e] = t;
                ssum[e] = t;
                scnt[e] = 1;
                total++;
            end
            else
                full_flag = 1;
        end
        clear_line();
    endfunction

    function automatic void take_char(input logic [7:0] b);
        int v;
        if (b == CH_NL)
        begin
            close_line();
            return;
        end
        if (ph == PH_NAME || ph == PH_NAME_LONG)
        begin
            if (b == CH_SEMI)
                ph = (ph == PH_NAME) ? PH_TEMP : PH_TEMP_LONG;
            else if (ph == PH_NAME)
            begin
                if (nlen < MAX_NAME_BYTES)
                begin
                    lbuf[nlen] = b;
                    nlen++;
                end
                else
                    ph = PH_NAME_LONG;
            end
            return;
        end
        if (tfirst && b == CH_MINUS)
        begin
            tneg   = 1;
            tfirst = 0;
            return;
        end
        tfirst = 0;
        if (b == CH_DOT)
            return;
        v = tacc * 10 + (int'(b) - int'(CH_ZERO));
        if (v > int'(TEMP_LIMIT)) v = int'(TEMP_LIMIT);
        if (v < -int'(TEMP_LIMIT)) v = -int'(TEMP_LIMIT);
        tacc = v;
    endfunction

    function automatic logic [159:0] stats_word(input logic [1:0] md, input int idx,
                                                input int off);
        logic [159:0] w;
        bit ok;
        w  = '0;
        ok = idx < total;
        if (ok)
        begin
            w[0]       = 1'b1;
            w[15:1]    = smin[idx][14:0];
            w[30:16]   = smax[idx][14:0];
            w[86:31]   = ssum[idx][55:0];
            w[126:87]  = scnt[idx][39:0];
            w[134:127] = slen[idx][7:0];
            if (md == MODE_NAME && off < slen[idx])
                w[142:135] = names[idx][off];
        end
        w[152:143] = total[9:0];
        w[153]     = full_flag;
        w[154]     = long_flag;
        return w;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [159:0] want;
        logic [159:0] mask;
        if (!rst_n)
        begin
            clear_line();
            total     = 0;
            full_flag = 0;
            long_flag = 0;
            expected_stats.delete();
            pending   = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_stats.size() == 0)
                    report("unexpected word", m_tdata, '0);
                else
                begin
                    want = expected_stats.pop_front();
                    for (int f = 0; f < NF; f++)
                    begin
                        mask = (160'd1 << FW[f]) - 160'd1;
                        if (((m_tdata >> FLO[f]) & mask) != ((want >> FLO[f]) & mask))
                            report(FNAME[f], (m_tdata >> FLO[f]) & mask,
                                   (want >> FLO[f]) & mask);
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                case (s_tuser)
                    MODE_BYTE:  take_char(s_tdata[7:0]);
                    MODE_FLUSH: close_line();
                    default:    expected_stats.push_back(stats_word(s_tuser,
                                    int'(s_tdata[16:8]), int'(s_tdata[23:17])));
                endcase
            end
            pending = expected_stats.size();
        end
    end

endmodule

// ===== tb/tb_station_stats_aggregator_top.sv =====
`timescale 1ns / 1ps
module tb_station_stats_aggregator_top;
    import ssa_pkg::*;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [23:0]  s_tdata;   // data_byte, entry_index, name_offset
    logic [1:0]   s_tuser;   // mode
    logic         m_tvalid;
    logic         m_tready;
    logic [159:0] m_tdata;   // entry_valid, min_temp, max_temp, temp_sum, sample_count,
                             // name_length, name_byte, entries_used, table_full_drop,
                             // long_name_drop
    int           errors;
    int           pending;
    int           src_idle;
    int           rcv_stall;
    int           words_sent;

    station_stats_aggregator_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    station_stats_checker u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .errors   (errors),
        .pending  (pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= rcv_stall);

    initial
    begin
        #40ms;
        $display("tb_station_stats_aggregator_top NOT OK");
        $finish;
    end

    task automatic put_word(input logic [1:0] md, input logic [7:0] b, input logic [8:0] idx,
                            input logic [6:0] off);
        if ($urandom_range(99) < src_idle)
        begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < src_idle);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= md;
        s_tdata  <= {off, idx, b};
        do @(posedge clk); while (!s_tready);
        words_sent++;
    endtask

    task automatic put_char(input logic [7:0] b);
        put_word(MODE_BYTE, b, 9'($urandom), 7'($urandom));
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            put_char(s[i]);
    endtask

    task automatic put_read(input logic [1:0] md, input logic [8:0] idx, input logic [6:0] off);
        put_word(md, 8'($urandom), idx, off);
    endtask

    task automatic idle_out();
        s_tvalid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
    endtask

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do c = 8'($urandom); while (c == CH_SEMI || c == CH_NL);
        return c;
    endfunction

    task automatic random_line();
        int n;
        if ($urandom_range(99) < 3)
        begin
            n = $urandom_range(MAX_NAME_BYTES - 2, MAX_NAME_BYTES + 4);
            for (int i = 0; i < n; i++)
                put_char(plain_char());
        end
        else
        begin
            n = $urandom_range(0, 3);
            for (int i = 0; i < n; i++)
                put_char(8'h61 + 8'($urandom_range(0, 2)));
        end
        if ($urandom_range(99) >= 5)
            put_char(CH_SEMI);
        if ($urandom_range(1))
            put_char(CH_MINUS);
        n = ($urandom_range(99) < 5) ? 6 : $urandom_range(0, 3);
        for (int i = 0; i < n; i++)
        begin
            if (i == n - 1 && n > 1 && $urandom_range(1))
                put_char(CH_DOT);
            if ($urandom_range(99) < 8)
                put_char(8'($urandom));
            else
                put_char(CH_ZERO + 8'($urandom_range(0, 9)));
        end
        case ($urandom_range(0, 9))
            0, 1:    put_word(MODE_FLUSH, 8'($urandom), 9'($urandom), 7'($urandom));
            2:       ;
            default: put_char(CH_NL);
        endcase
    endtask

    task automatic random_read();
        logic [8:0] idx;
        logic [6:0] off;
        idx = ($urandom_range(99) < 80) ? 9'($urandom_range(0, 15)) : 9'($urandom);
        off = ($urandom_range(99) < 80) ? 7'($urandom_range(0, 4)) : 7'($urandom);
        put_read($urandom_range(1) ? MODE_STATS : MODE_NAME, idx, off);
    endtask

    initial
    begin
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = MODE_BYTE;
        m_tready   = 1'b0;
        src_idle   = 0;
        rcv_stall  = 0;
        words_sent = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        put_word(MODE_FLUSH, 8'h00, 9'h000, 7'h00);
        put_text("a;12.3\n");
        put_text("a;-99.9\n");
        put_text(";\n");
        put_text("x9\n");
        put_text("b;1-;\n");
        put_text("c;99999\n");
        put_text("a;5");
        put_word(MODE_FLUSH, 8'hFF, 9'h1FF, 7'h7F);
        put_read(MODE_STATS, 9'd0, 7'd0);
        put_read(MODE_NAME, 9'd0, 7'd0);
        put_read(MODE_NAME, 9'd0, 7'h7F);
        put_read(MODE_STATS, 9'h1FF, 7'h7F);
        put_read(MODE_NAME, 9'd3, 7'd0);
        idle_out();

        while (words_sent < 460)
        begin
            case (words_sent / 115)
                0:       begin src_idle = 0;  rcv_stall = 0;  end
                1:       begin src_idle = 60; rcv_stall = 0;  end
                2:       begin src_idle = 0;  rcv_stall = 60; end
                default: begin src_idle = 17; rcv_stall = 17; end
            endcase
            case ($urandom_range(0, 9))
                0:       put_word(2'($urandom), 8'($urandom), 9'($urandom), 7'($urandom));
                1, 2, 3: random_read();
                default: random_line();
            endcase
            if (words_sent > 230 && words_sent < 250)
                idle_out();
        end
        put_char(CH_NL);
        idle_out();

        src_idle  = 0;
        rcv_stall = 0;
        put_read(MODE_STATS, 9'h1FF, 7'd0);
        put_read(MODE_NAME, 9'h1FF, 7'd1);
        put_read(MODE_NAME, 9'h1FE, 7'd0);
        rcv_stall = 30;
        for (int i = 0; i < 20; i++)
            random_read();
        s_tvalid <= 1'b0;

        wait (pending == 0);
        repeat (3000) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("tb_station_stats_aggregator_top OK");
        else
            $display("tb_station_stats_aggregator_top NOT OK");
        $finish;
    end

endmodule

// ===== sim.f =====
design/ssa_pkg.sv
design/station_stats_aggregator_top.sv
tb/station_stats_checker.sv
tb/tb_station_stats_aggregator_top.sv
